>>> src/autoranging_period_tachometer_macros.svh
// Assertion macros for the autoranging period tachometer.
// Included by the top level; depends on nothing else.
`ifndef AUTORANGING_PERIOD_TACHOMETER_MACROS_SVH
`define AUTORANGING_PERIOD_TACHOMETER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ATACH_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("atach: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define ATACH_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("atach: next-cycle check failed");

`endif

>>> src/atach_pkg.sv
// Shared types and constants for the autoranging period tachometer.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package atach_pkg;

   // Field widths
   localparam int STAMP_BITS   = 16;
   localparam int LIMIT_BITS   = 8;
   localparam int TARGET_BITS  = 32;
   localparam int WINDOW_BITS  = 8;
   localparam int SUM_BITS     = 32;
   localparam int RPM_BITS     = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   // Timer width default
   localparam int TIMER_BITS_DEFAULT = 16;

   // Speed scaling
   localparam logic [31:0] RPM_NUMERATOR   = 32'd15360000;
   localparam logic [SUM_BITS-1:0] MIN_SUM_FOR_RPM = 32'd50;
   localparam logic [WINDOW_BITS-1:0] WINDOW_CAP   = 8'd128;

   // Divider widths: numerator * 128 stays below 2^31
   localparam int DIVIDEND_BITS = 31;
   localparam int DIVISOR_BITS  = SUM_BITS;
   localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_OVERFLOW_LIMIT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD_TARGET  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_WINDOW     = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_WINDOW     = 2'd3;

   // Register reset values
   localparam logic [LIMIT_BITS-1:0]  OVERFLOW_LIMIT_RESET = 8'd8;
   localparam logic [TARGET_BITS-1:0] PERIOD_TARGET_RESET  = 32'd51200;
   localparam logic [WINDOW_BITS-1:0] MIN_WINDOW_RESET     = 8'd1;
   localparam logic [WINDOW_BITS-1:0] MAX_WINDOW_RESET     = 8'd64;

   // Request kinds
   localparam logic OP_CAPTURE  = 1'b0;
   localparam logic OP_OVERFLOW = 1'b1;

   typedef struct packed {
      logic [LIMIT_BITS-1:0]  overflow_limit;
      logic [TARGET_BITS-1:0] period_target;
      logic [WINDOW_BITS-1:0] min_window;
      logic [WINDOW_BITS-1:0] max_window;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

endpackage

>>> src/autoranging_period_tachometer.sv
// Top level of the autoranging period tachometer: registers, sequencer, result stage.
// Depends on atach_pkg, atach_update, atach_div and the assertion macro header.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    operation, timestamp
//   rsp_      out         rsp_valid/rsp_ready    rpm, period_sum, window_count
//   csr_      in          csr_valid/csr_ready    index, wdata
//
// A request is accepted only in the idle state. The window state is updated at the
// acceptance edge itself. After that the sequencer loads the divider, waits in the
// bit-serial divider until it sees the done flag, and then moves the quotient into
// the result register. The next request is taken once the sequencer is idle again.
// Reset is synchronous and active high; it restores the register defaults.
// A pending result does not block the next request; only the final move waits
// for the result register to empty.
`timescale 1ns / 1ps
`include "autoranging_period_tachometer_macros.svh"

module autoranging_period_tachometer #(
   parameter int TIMER_BITS = atach_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic [atach_pkg::STAMP_BITS-1:0]      req_timestamp,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [atach_pkg::RPM_BITS-1:0]        rsp_rpm,
   output logic [atach_pkg::SUM_BITS-1:0]        rsp_period_sum,
   output logic [atach_pkg::WINDOW_BITS-1:0]     rsp_window_count,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [atach_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [atach_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int NB  = atach_pkg::DIVIDEND_BITS;
   localparam int RB  = atach_pkg::RPM_BITS;

   // ---------------------------------------------------------------------------
   // Configuration registers: always writable, one write per cycle
   // ---------------------------------------------------------------------------
   atach_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            atach_pkg::CSR_OVERFLOW_LIMIT:
               cfg_in.overflow_limit = csr_wdata[atach_pkg::LIMIT_BITS-1:0];
            atach_pkg::CSR_PERIOD_TARGET:
               cfg_in.period_target  = csr_wdata[atach_pkg::TARGET_BITS-1:0];
            atach_pkg::CSR_MIN_WINDOW:
               cfg_in.min_window     = csr_wdata[atach_pkg::WINDOW_BITS-1:0];
            atach_pkg::CSR_MAX_WINDOW:
               cfg_in.max_window     = csr_wdata[atach_pkg::WINDOW_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overflow_limit <= atach_pkg::OVERFLOW_LIMIT_RESET;
         cfg_ff.period_target  <= atach_pkg::PERIOD_TARGET_RESET;
         cfg_ff.min_window     <= atach_pkg::MIN_WINDOW_RESET;
         cfg_ff.max_window     <= atach_pkg::MAX_WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   atach_pkg::state_type       state_ff, state_in;
   atach_pkg::div_status_type  div_status;
   logic                       req_accept;
   logic                       div_start;
   logic                       out_free;
   logic                       out_load;

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         atach_pkg::ST_IDLE:    if (req_valid) state_in = atach_pkg::ST_START;
         atach_pkg::ST_START:   state_in = atach_pkg::ST_DIVIDE;
         atach_pkg::ST_DIVIDE:  if (div_status.done) state_in = atach_pkg::ST_DELIVER;
         atach_pkg::ST_DELIVER: if (out_free) state_in = atach_pkg::ST_IDLE;
         default:               state_in = atach_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         atach_pkg::ST_IDLE:    req_ready = 1'b1;
         atach_pkg::ST_START:   div_start = 1'b1;
         atach_pkg::ST_DIVIDE:  ;
         atach_pkg::ST_DELIVER: out_load  = out_free;
         default:               ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atach_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Window state: apply the request at its acceptance edge
   // ---------------------------------------------------------------------------
   logic [atach_pkg::SUM_BITS-1:0]    reported_sum;
   logic [atach_pkg::WINDOW_BITS-1:0] reported_window;

   atach_update #(
      .TIMER_BITS(TIMER_BITS)
   ) u_update (
      .clock           (clock),
      .reset           (reset),
      .apply           (req_accept),
      .operation       (req_operation),
      .timestamp       (req_timestamp),
      .cfg             (cfg_ff),
      .reported_sum    (reported_sum),
      .reported_window (reported_window)
   );

   // ---------------------------------------------------------------------------
   // Speed: numerator times window, divided by the summed count
   // ---------------------------------------------------------------------------
   logic [31:0]   product;
   logic [NB-1:0] quotient;
   logic [RB-1:0] rpm_value;

   // numerator * 128 stays below 2^31, so the top bit always drops
   assign product = atach_pkg::RPM_NUMERATOR * 32'(reported_window);

   atach_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product[NB-1:0]),
      .divisor  (reported_sum),
      .status   (div_status),
      .quotient (quotient)
   );

   // zero for a tiny sum, saturate a large quotient
   always_comb begin
      if (reported_sum <= atach_pkg::MIN_SUM_FOR_RPM) begin
         rpm_value = '0;
      end else if (|quotient[NB-1:RB]) begin
         rpm_value = {RB{1'b1}};
      end else begin
         rpm_value = quotient[RB-1:0];
      end
   end

   // ---------------------------------------------------------------------------
   // Result register: hold until taken
   // ---------------------------------------------------------------------------
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [RB-1:0]                     rsp_rpm_ff;
   logic [atach_pkg::SUM_BITS-1:0]    rsp_sum_ff;
   logic [atach_pkg::WINDOW_BITS-1:0] rsp_window_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_rpm_ff    <= rpm_value;
         rsp_sum_ff    <= reported_sum;
         rsp_window_ff <= reported_window;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rpm          = rsp_rpm_ff;
   assign rsp_period_sum   = rsp_sum_ff;
   assign rsp_window_count = rsp_window_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   `ATACH_ASSERT_NEXT(a_busy_after_req, clock, reset, req_accept, !req_ready)
   `ATACH_ASSERT_SAME(a_done_in_divide, clock, reset, div_status.done,
                      state_ff == atach_pkg::ST_DIVIDE)
   `ATACH_ASSERT_SAME(a_rpm_needs_sum, clock, reset, rsp_valid && rsp_rpm != '0,
                      rsp_period_sum > atach_pkg::MIN_SUM_FOR_RPM)
   `ATACH_ASSERT_SAME(a_window_in_range, clock, reset, rsp_valid,
                      rsp_window_count <= atach_pkg::WINDOW_CAP)

endmodule

>>> src/atach_update.sv
// Measurement and window state of the tachometer: applies one request per pulse.
// Depends on atach_pkg.
`timescale 1ns / 1ps

module atach_update #(
   parameter int TIMER_BITS = atach_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   apply,
   input  logic                                   operation,
   input  logic [atach_pkg::STAMP_BITS-1:0]       timestamp,
   input  atach_pkg::cfg_type                     cfg,
   output logic [atach_pkg::SUM_BITS-1:0]         reported_sum,
   output logic [atach_pkg::WINDOW_BITS-1:0]      reported_window
);

   localparam int COUNT_BITS = TIMER_BITS + atach_pkg::LIMIT_BITS;
   localparam int SUM_BITS   = atach_pkg::SUM_BITS;
   localparam int WIN_BITS   = atach_pkg::WINDOW_BITS;
   localparam int LIM_BITS   = atach_pkg::LIMIT_BITS;

   logic [LIM_BITS-1:0]   overflow_count_ff, overflow_count_in;
   logic [TIMER_BITS-1:0] last_stamp_ff, last_stamp_in;
   logic [WIN_BITS-1:0]   event_index_ff, event_index_in;
   logic [WIN_BITS-1:0]   window_size_ff, window_size_in;
   logic [SUM_BITS-1:0]   running_sum_ff, running_sum_in;
   logic [SUM_BITS-1:0]   reported_sum_ff, reported_sum_in;
   logic [WIN_BITS-1:0]   reported_window_ff, reported_window_in;

   logic [31:0]           stamp_wide;
   logic [TIMER_BITS-1:0] stamp;
   logic [TIMER_BITS-1:0] diff;
   logic                  stalled;
   logic                  stamp_ge;
   logic [LIM_BITS-1:0]   spans;
   logic [COUNT_BITS-1:0] count;
   logic [SUM_BITS:0]     total;
   logic [SUM_BITS-1:0]   new_sum;
   logic [WIN_BITS-1:0]   index_inc;
   logic                  window_end;

   assign stamp_wide = 32'(timestamp);
   assign stamp      = stamp_wide[TIMER_BITS-1:0];
   assign diff       = stamp - last_stamp_ff;
   assign stalled    = overflow_count_ff >= cfg.overflow_limit;
   assign stamp_ge   = stamp >= last_stamp_ff;

   // Extra whole timer spans sit above the wrapped difference
   assign spans = (overflow_count_ff == '0) ? '0
                : overflow_count_ff - LIM_BITS'(1) + LIM_BITS'(stamp_ge);
   assign count = {spans, diff};

   assign total   = {1'b0, running_sum_ff} + (SUM_BITS + 1)'(count);
   assign new_sum = total[SUM_BITS] ? {SUM_BITS{1'b1}} : total[SUM_BITS-1:0];

   assign index_inc  = event_index_ff + WIN_BITS'(1);
   assign window_end = index_inc >= window_size_ff;

   always_comb begin
      overflow_count_in  = overflow_count_ff;
      last_stamp_in      = last_stamp_ff;
      event_index_in     = event_index_ff;
      window_size_in     = window_size_ff;
      running_sum_in     = running_sum_ff;
      reported_sum_in    = reported_sum_ff;
      reported_window_in = reported_window_ff;
      if (apply) begin
         if (operation == atach_pkg::OP_OVERFLOW) begin
            if (stalled) begin
               reported_window_in = '0;
               event_index_in     = '0;
            end else begin
               overflow_count_in = overflow_count_ff + LIM_BITS'(1);
            end
         end else if (stalled) begin
            // restart after a stall: clear the partial window and take the new stamp
            overflow_count_in = '0;
            running_sum_in    = '0;
            event_index_in    = '0;
            last_stamp_in     = stamp;
         end else begin
            overflow_count_in = '0;
            last_stamp_in     = stamp;
            if (window_end) begin
               reported_sum_in    = new_sum;
               reported_window_in = window_size_ff;
               event_index_in     = '0;
               running_sum_in     = '0;
               if (new_sum > cfg.period_target && window_size_ff > cfg.min_window) begin
                  if (window_size_ff > WIN_BITS'(1)) begin
                     window_size_in = window_size_ff >> 1;
                  end
               end else if (new_sum < (cfg.period_target >> 1)
                            && window_size_ff < cfg.max_window) begin
                  if (window_size_ff < atach_pkg::WINDOW_CAP) begin
                     window_size_in = window_size_ff << 1;
                  end
               end
            end else begin
               event_index_in = index_inc;
               running_sum_in = new_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overflow_count_ff  <= '0;
         last_stamp_ff      <= '0;
         event_index_ff     <= '0;
         window_size_ff     <= WIN_BITS'(1);
         running_sum_ff     <= '0;
         reported_sum_ff    <= '0;
         reported_window_ff <= '0;
      end else begin
         overflow_count_ff  <= overflow_count_in;
         last_stamp_ff      <= last_stamp_in;
         event_index_ff     <= event_index_in;
         window_size_ff     <= window_size_in;
         running_sum_ff     <= running_sum_in;
         reported_sum_ff    <= reported_sum_in;
         reported_window_ff <= reported_window_in;
      end
   end

   assign reported_sum    = reported_sum_ff;
   assign reported_window = reported_window_ff;

endmodule

>>> src/atach_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on atach_pkg.
`timescale 1ns / 1ps

module atach_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [atach_pkg::DIVIDEND_BITS-1:0]   dividend,
   input  logic [atach_pkg::DIVISOR_BITS-1:0]    divisor,
   output atach_pkg::div_status_type             status,
   output logic [atach_pkg::DIVIDEND_BITS-1:0]   quotient
);

   localparam int NB = atach_pkg::DIVIDEND_BITS;
   localparam int DB = atach_pkg::DIVISOR_BITS;
   localparam int CB = atach_pkg::DIV_CNT_BITS;
   localparam logic [CB-1:0] LAST_STEP = CB'(NB - 1);

   logic [DB-1:0] rem_ff, rem_in;
   logic [NB-1:0] quo_ff, quo_in;
   logic [DB-1:0] div_ff, div_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [DB:0]   trial;
   logic [DB:0]   diff;
   logic          fits;

   assign trial = {rem_ff, quo_ff[NB-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DB-1:0] : trial[DB-1:0];
         quo_in = {quo_ff[NB-2:0], fits};
         cnt_in = cnt_ff + CB'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule
